[rtl/mlo_pkg.sv]
// ----------------------------------------------------------------------------
// mlo_pkg
// Shared widths, register indexes and sequencer states of the mouse-look unit.
// ----------------------------------------------------------------------------
`default_nettype none

package mlo_pkg;

  localparam int unsigned PIX_W      = 12;
  localparam int unsigned TIME_W     = 16;
  localparam int unsigned GAIN_W     = 20;
  localparam int unsigned LIMIT_W    = 15;
  localparam int unsigned POS_W      = 32;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned STEP_SHIFT = 24;  // gain Q.8 times time Q0.16

  // vector format, shared by the datapath and the result channel
  localparam int unsigned VECTOR_FRAC_BITS = 14;
  localparam int unsigned VEC_W            = VECTOR_FRAC_BITS + 2;

  localparam logic [PIX_W-1:0]   CENTRE_X_RST    = 12'd640;
  localparam logic [PIX_W-1:0]   CENTRE_Y_RST    = 12'd360;
  localparam logic [GAIN_W-1:0]  LOOK_GAIN_RST   = 20'd233017;
  localparam logic [LIMIT_W-1:0] PITCH_LIMIT_RST = 15'd15474;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POS_X       = 3'd0,
    CFG_POS_Y       = 3'd1,
    CFG_POS_Z       = 3'd2,
    CFG_CENTRE_X    = 3'd3,
    CFG_CENTRE_Y    = 3'd4,
    CFG_LOOK_GAIN   = 3'd5,
    CFG_PITCH_LIMIT = 3'd6
  } cfg_reg_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_GD,
    S_DY,
    S_DP,
    S_LOOK,
    S_VX,
    S_VZ,
    S_UX,
    S_UZ,
    S_UY0,
    S_UY1,
    S_DONE
  } state_e;

endpackage

`default_nettype wire

[rtl/mlo_in_if.sv]
// ----------------------------------------------------------------------------
// mlo_in_if
// Pointer sample channel: valid/ready with mode, pointer and frame time.
// ----------------------------------------------------------------------------
`default_nettype none

interface mlo_in_if;
  import mlo_pkg::*;

  logic              valid;
  logic              ready;
  logic              mode;
  logic [PIX_W-1:0]  mouse_x;
  logic [PIX_W-1:0]  mouse_y;
  logic [TIME_W-1:0] frame_time;

  modport source (output valid, output mode, output mouse_x, output mouse_y,
                  output frame_time, input ready);
  modport sink   (input valid, input mode, input mouse_x, input mouse_y,
                  input frame_time, output ready);
endinterface

`default_nettype wire

[rtl/mlo_out_if.sv]
// ----------------------------------------------------------------------------
// mlo_out_if
// Camera basis channel: valid/ready with view, right, up and target.
// ----------------------------------------------------------------------------
`default_nettype none

interface mlo_out_if;
  import mlo_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [VEC_W-1:0] view_x;
  logic signed [VEC_W-1:0] view_y;
  logic signed [VEC_W-1:0] view_z;
  logic signed [VEC_W-1:0] right_x;
  logic signed [VEC_W-1:0] right_z;
  logic signed [VEC_W-1:0] up_x;
  logic signed [VEC_W-1:0] up_y;
  logic signed [VEC_W-1:0] up_z;
  logic signed [POS_W-1:0] target_x;
  logic signed [POS_W-1:0] target_y;
  logic signed [POS_W-1:0] target_z;

  modport source (output valid, output view_x, output view_y, output view_z,
                  output right_x, output right_z, output up_x, output up_y,
                  output up_z, output target_x, output target_y,
                  output target_z, input ready);
  modport sink   (input valid, input view_x, input view_y, input view_z,
                  input right_x, input right_z, input up_x, input up_y,
                  input up_z, input target_x, input target_y,
                  input target_z, output ready);
endinterface

`default_nettype wire

[rtl/mouse_look_orientation.sv]
// Throughput: one beat at a time, paced by the shift-add multiplier at one
// multiplier bit per cycle. A new beat is taken while a finished result waits.
// Reset: asynchronous, clears angles, sequencer and configuration registers to defaults.
// ----------------------------------------------------------------------------
// mouse_look_orientation
// Yaw/pitch camera: serial angle update, quarter-wave sine lookup and a
// shift-add multiplier building view, right, up and target vectors.
// ----------------------------------------------------------------------------
`default_nettype none

module mouse_look_orientation #(
  parameter int unsigned ANGLE_BITS       = 16,
  parameter int unsigned SINE_TABLE_DEPTH = 1024
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [mlo_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [mlo_pkg::CFG_DATA_W-1:0] cfg_data_i,
  mlo_in_if.sink                              in_i,
  mlo_out_if.source                           out_o
);
  import mlo_pkg::*;

  localparam int unsigned AB      = ANGLE_BITS;
  localparam int unsigned VF      = VECTOR_FRAC_BITS;
  localparam int unsigned VW      = VF + 2;
  localparam int unsigned OFF_W   = PIX_W + 1;
  localparam int unsigned GD_W    = GAIN_W + TIME_W;
  localparam int unsigned ACC_W   = GD_W + OFF_W + 1;
  localparam int unsigned MPW     = (VW > TIME_W) ? VW : TIME_W;
  localparam int unsigned CNT_W   = $clog2(MPW + 1);
  localparam int unsigned DP_W    = ACC_W - STEP_SHIFT;
  localparam int unsigned CW      = ((DP_W > AB) ? DP_W : AB) + 1;
  localparam int unsigned DEPTH_W = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int unsigned QB      = AB - 2;
  localparam int unsigned IDX_W   = QB + DEPTH_W + 1;
  localparam logic [AB-1:0] QUARTER = AB'(1) << QB;
  localparam logic signed [VW-1:0]    ONE_V  = VW'(2 ** VF);
  localparam logic signed [ACC_W-1:0] ONE_A  = ACC_W'(2 ** VF);
  localparam logic signed [ACC_W-1:0] HALF_A = ACC_W'(2 ** (VF - 1));

  // quarter-wave sine table, Taylor series in Q30
  function automatic logic [VF:0] sine_entry(input int unsigned i);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint      sum;
    int          k;
    x    = (64'd1686629713 * 64'(i) + 64'(SINE_TABLE_DEPTH / 2))
           / 64'(SINE_TABLE_DEPTH);
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (k = 1; k <= 10; k++) begin
      term = (term * x2) >> 30;
      term = term / 64'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) sum = sum - longint'(term);
      else            sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    if (sum > (64'sd1 <<< 30)) sum = 64'sd1 <<< 30;
    sum = (sum + (64'sd1 <<< (29 - VF))) >>> (30 - VF);
    return sum[VF:0];
  endfunction

  logic [VF:0] rom_w [SINE_TABLE_DEPTH+1];
  for (genvar g = 0; g <= SINE_TABLE_DEPTH; g++) begin : g_rom
    localparam logic [VF:0] ENTRY = sine_entry(g);
    assign rom_w[g] = ENTRY;
  end

  // configuration
  logic signed [POS_W-1:0] pos_x_q, pos_y_q, pos_z_q;
  logic [PIX_W-1:0]        centre_x_q, centre_y_q;
  logic [GAIN_W-1:0]       gain_q;
  logic [LIMIT_W-1:0]      limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q    <= '0;
      pos_y_q    <= '0;
      pos_z_q    <= '0;
      centre_x_q <= CENTRE_X_RST;
      centre_y_q <= CENTRE_Y_RST;
      gain_q     <= LOOK_GAIN_RST;
      limit_q    <= PITCH_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_POS_X:       pos_x_q    <= cfg_data_i;
        CFG_POS_Y:       pos_y_q    <= cfg_data_i;
        CFG_POS_Z:       pos_z_q    <= cfg_data_i;
        CFG_CENTRE_X:    centre_x_q <= cfg_data_i[PIX_W-1:0];
        CFG_CENTRE_Y:    centre_y_q <= cfg_data_i[PIX_W-1:0];
        CFG_LOOK_GAIN:   gain_q     <= cfg_data_i[GAIN_W-1:0];
        CFG_PITCH_LIMIT: limit_q    <= cfg_data_i[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  state_e             state_q, state_d;
  logic               run_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [2:0]         lk_q;
  logic               out_valid_q;
  logic               mul_st, mul_fin, in_acc, out_free;

  logic               mode_q;
  logic [PIX_W-1:0]   mx_q, my_q;
  logic [TIME_W-1:0]  dt_q;
  logic [AB-1:0]      yaw_q, pitch_q;
  logic [GD_W-1:0]    gd_q;

  logic signed [ACC_W-1:0] acc_q, mcand_q;
  logic [MPW-1:0]          mpl_q;
  logic                    sgn_q, neg_q;

  logic signed [VW-1:0] cp_q, sy_q, cy_q;
  logic signed [VW-1:0] vx_q, vy_q, vz_q;
  logic signed [VW-1:0] ux_q, uz_q;
  logic [VF:0]          rom_q;
  logic                 rneg_q;

  assign mul_st   = (state_q inside {S_GD, S_DY, S_DP, S_VX, S_VZ, S_UX, S_UZ,
                                     S_UY0, S_UY1});
  assign mul_fin  = run_q && (cnt_q == '0);
  assign in_acc   = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_i.valid) state_d = in_i.mode ? S_LOOK : S_GD;
      S_GD:   if (mul_fin) state_d = S_DY;
      S_DY:   if (mul_fin) state_d = S_DP;
      S_DP:   if (mul_fin) state_d = S_LOOK;
      S_LOOK: if (lk_q == 3'd4) state_d = mode_q ? S_UX : S_VX;
      S_VX:   if (mul_fin) state_d = S_VZ;
      S_VZ:   if (mul_fin) state_d = S_UX;
      S_UX:   if (mul_fin) state_d = S_UZ;
      S_UZ:   if (mul_fin) state_d = S_UY0;
      S_UY0:  if (mul_fin) state_d = S_UY1;
      S_UY1:  if (mul_fin) state_d = S_DONE;
      S_DONE: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // multiplier operand selection
  logic signed [ACC_W-1:0] ld_mcand;
  logic [MPW-1:0]          ld_mpl;
  logic [CNT_W-1:0]        ld_n;
  logic                    ld_sgn, ld_neg, ld_keep;
  logic [OFF_W-1:0]        offx, offy;
  logic signed [VW-1:0]    rx_w;

  assign offx = {1'b0, centre_x_q} - {1'b0, mx_q};
  assign offy = {1'b0, centre_y_q} - {1'b0, my_q};
  assign rx_w = -cy_q;

  always_comb begin
    ld_mcand = ACC_W'(sy_q);
    ld_mpl   = MPW'($unsigned(vy_q));
    ld_n     = CNT_W'(VW);
    ld_sgn   = 1'b1;
    ld_neg   = 1'b0;
    ld_keep  = 1'b0;
    case (state_q)
      S_GD: begin
        ld_mcand = ACC_W'(gain_q);
        ld_mpl   = MPW'(dt_q);
        ld_n     = CNT_W'(TIME_W);
        ld_sgn   = 1'b0;
      end
      S_DY: begin
        ld_mcand = ACC_W'(gd_q);
        ld_mpl   = MPW'(offx);
        ld_n     = CNT_W'(OFF_W);
      end
      S_DP: begin
        ld_mcand = ACC_W'(gd_q);
        ld_mpl   = MPW'(offy);
        ld_n     = CNT_W'(OFF_W);
      end
      S_VX: begin
        ld_mcand = ACC_W'(cp_q);
        ld_mpl   = MPW'($unsigned(sy_q));
      end
      S_VZ: begin
        ld_mcand = ACC_W'(cp_q);
        ld_mpl   = MPW'($unsigned(cy_q));
      end
      S_UX: ld_neg = 1'b1;
      S_UZ: ld_mcand = ACC_W'(rx_w);
      S_UY0: ld_mpl = MPW'($unsigned(vx_q));
      S_UY1: begin
        ld_mcand = ACC_W'(rx_w);
        ld_mpl   = MPW'($unsigned(vz_q));
        ld_neg   = 1'b1;
        ld_keep  = 1'b1;
      end
      default: ;
    endcase
  end

  // result shaping
  logic signed [ACC_W-1:0] rnd_w;
  logic signed [VW-1:0]    vec_w;
  logic signed [DP_W-1:0]  dp_w;
  logic signed [CW-1:0]    cand_w, lim_w;
  logic                    pitch_ok;

  always_comb begin
    rnd_w = (acc_q + HALF_A) >>> VF;
    if (rnd_w > ONE_A)       vec_w = ONE_V;
    else if (rnd_w < -ONE_A) vec_w = -ONE_V;
    else                     vec_w = rnd_w[VW-1:0];
  end

  assign dp_w     = acc_q[ACC_W-1:STEP_SHIFT];
  assign cand_w   = CW'($signed(pitch_q)) + CW'(dp_w);
  assign lim_w    = CW'(limit_q);
  assign pitch_ok = (cand_w < lim_w) && (cand_w > -lim_w);

  // sine lookup address
  logic [AB-1:0]      ang_w;
  logic [1:0]         quad_w;
  logic [IDX_W-1:0]   idx_full;
  logic [DEPTH_W-1:0] idx_w, addr_w;

  always_comb begin
    ang_w = lk_q[1] ? yaw_q : pitch_q;
    if (lk_q[0]) ang_w = ang_w + QUARTER;
  end

  assign quad_w   = ang_w[AB-1:AB-2];
  assign idx_full = (IDX_W'(ang_w[QB-1:0]) * IDX_W'(SINE_TABLE_DEPTH)
                     + IDX_W'(QUARTER >> 1)) >> QB;
  assign idx_w    = idx_full[DEPTH_W-1:0];
  assign addr_w   = quad_w[0] ? DEPTH_W'(SINE_TABLE_DEPTH) - idx_w : idx_w;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q       <= 1'b0;
      cnt_q       <= '0;
      lk_q        <= '0;
      out_valid_q <= 1'b0;
      yaw_q       <= '0;
      pitch_q     <= '0;
    end else begin
      if (mul_st) begin
        if (!run_q) begin
          run_q <= 1'b1;
          cnt_q <= ld_n;
        end else if (cnt_q != '0) begin
          cnt_q <= cnt_q - 1'b1;
        end else begin
          run_q <= 1'b0;
        end
      end
      lk_q <= (state_q == S_LOOK) ? lk_q + 3'd1 : 3'd0;
      if (state_q == S_DY && mul_fin) yaw_q <= yaw_q + acc_q[STEP_SHIFT +: AB];
      if (state_q == S_DP && mul_fin && pitch_ok) pitch_q <= cand_w[AB-1:0];
      if (state_q == S_DONE && out_free) out_valid_q <= 1'b1;
      else if (out_o.ready)              out_valid_q <= 1'b0;
    end
  end

  // datapath
  logic signed [VW-1:0] rom_s;
  assign rom_s = rneg_q ? -VW'(rom_q) : VW'(rom_q);

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mode_q <= in_i.mode;
      mx_q   <= in_i.mouse_x;
      my_q   <= in_i.mouse_y;
      dt_q   <= in_i.frame_time;
      if (in_i.mode) begin
        vx_q <= '0;
        vy_q <= '0;
        vz_q <= ONE_V;
      end
    end
    if (mul_st) begin
      if (!run_q) begin
        mcand_q <= ld_mcand;
        mpl_q   <= ld_mpl;
        sgn_q   <= ld_sgn;
        neg_q   <= ld_neg;
        if (!ld_keep) acc_q <= '0;
      end else if (cnt_q != '0) begin
        if (mpl_q[0]) begin
          if (((cnt_q == CNT_W'(1)) && sgn_q) ^ neg_q) acc_q <= acc_q - mcand_q;
          else                                           acc_q <= acc_q + mcand_q;
        end
        mcand_q <= mcand_q <<< 1;
        mpl_q   <= mpl_q >> 1;
      end
    end
    if (state_q == S_GD && mul_fin) gd_q <= acc_q[GD_W-1:0];
    if (state_q == S_LOOK) begin
      rom_q  <= rom_w[addr_w];
      rneg_q <= quad_w[1];
      case (lk_q)
        3'd1: if (!mode_q) vy_q <= rom_s;
        3'd2: cp_q <= rom_s;
        3'd3: sy_q <= rom_s;
        3'd4: cy_q <= rom_s;
        default: ;
      endcase
    end
    if (mul_fin) begin
      case (state_q)
        S_VX: vx_q <= vec_w;
        S_VZ: vz_q <= vec_w;
        S_UX: ux_q <= vec_w;
        S_UZ: uz_q <= vec_w;
        default: ;
      endcase
    end
  end

  // output register
  logic signed [POS_W:0] tx_w, ty_w, tz_w;
  logic signed [POS_W-1:0] tx_s, ty_s, tz_s;
  localparam logic signed [POS_W-1:0] T_MAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic signed [POS_W-1:0] T_MIN = {1'b1, {(POS_W-1){1'b0}}};

  assign tx_w = (POS_W+1)'(pos_x_q) + (POS_W+1)'(vx_q);
  assign ty_w = (POS_W+1)'(pos_y_q) + (POS_W+1)'(vy_q);
  assign tz_w = (POS_W+1)'(pos_z_q) + (POS_W+1)'(vz_q);
  assign tx_s = (tx_w[POS_W] != tx_w[POS_W-1]) ? (tx_w[POS_W] ? T_MIN : T_MAX)
                                               : tx_w[POS_W-1:0];
  assign ty_s = (ty_w[POS_W] != ty_w[POS_W-1]) ? (ty_w[POS_W] ? T_MIN : T_MAX)
                                               : ty_w[POS_W-1:0];
  assign tz_s = (tz_w[POS_W] != tz_w[POS_W-1]) ? (tz_w[POS_W] ? T_MIN : T_MAX)
                                               : tz_w[POS_W-1:0];

  always_ff @(posedge clk_i) begin
    if (state_q == S_DONE && out_free) begin
      out_o.view_x   <= vx_q;
      out_o.view_y   <= vy_q;
      out_o.view_z   <= vz_q;
      out_o.right_x  <= rx_w;
      out_o.right_z  <= sy_q;
      out_o.up_x     <= ux_q;
      out_o.up_y     <= vec_w;
      out_o.up_z     <= uz_q;
      out_o.target_x <= tx_s;
      out_o.target_y <= ty_s;
      out_o.target_z <= tz_s;
    end
  end

  assign out_o.valid = out_valid_q;

`ifndef SYNTHESIS
  a_cnt_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0) |-> run_q)
    else $error("multiplier count without run");
  a_yaw_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_DY) |=> $stable(yaw_q))
    else $error("yaw changed outside its update");
  a_fixed_view: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && mode_q) |-> (vz_q == ONE_V && vx_q == '0))
    else $error("fixed view not straight ahead");
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> (state_q != S_IDLE))
    else $error("accepted beat did not start");
`endif

endmodule

`default_nettype wire

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the mouse-look camera unit. Pointer beats come
// first from a short table and then from random phases, under several register
// settings. A behavioural yaw/pitch model predicts each camera basis beat, and
// the bench compares it field by field as the beat leaves the unit. Idling,
// stalls, a long output hold-off and a full drain are all exercised.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import mlo_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;
  localparam longint               ONE       = 16384;
  localparam int unsigned          DRAIN_CYC = 200;
  localparam int unsigned          CYC_LIMIT = 1500000;

  typedef struct {
    longint vx, vy, vz, rx, rz, ux, uy, uz, tx, ty, tz;
  } basis_t;

  typedef struct {
    bit               mode;
    logic [PIX_W-1:0] mx;
    logic [PIX_W-1:0] my;
    logic [TIME_W-1:0] dt;
    bit               typed;
  } look_row_t;

  localparam basis_t BASIS_FWD = '{0, 0, ONE, -ONE, 0, 0, ONE, 0, 0, 0, ONE};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  mlo_in_if  in_ch ();
  mlo_out_if out_ch ();

  mouse_look_orientation u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // camera model state
  longint       pos_x, pos_y, pos_z;
  longint       ctr_x, ctr_y, gain, plimit;
  logic [15:0]  yaw, pitch;
  int           sine_q14 [0:1024];

  basis_t       basis_q [$];
  int           mismatches = 0;
  bit           failed = 1'b0;
  int unsigned  send_idle = 0;
  int unsigned  recv_stall = 0;
  bit           hold_req = 1'b0;
  int unsigned  hold_left = 0;
  longint       cycles = 0;

  function automatic void build_sine();
    longint unsigned x, x2, term;
    longint          sum;
    for (int i = 0; i <= 1024; i++) begin
      x = (64'd1686629713 * i + 512) / 1024;
      x2 = (x * x) >> 30;
      term = x;
      sum = x;
      for (int k = 1; k <= 10; k++) begin
        term = (term * x2) >> 30;
        term = term / ((2 * k) * (2 * k + 1));
        if (k & 1) sum -= term;
        else sum += term;
      end
      if (sum < 0) sum = 0;
      if (sum > (64'sd1 << 30)) sum = 64'sd1 << 30;
      sine_q14[i] = int'((sum + (1 << 15)) >>> 16);
    end
  endfunction

  function automatic longint sin_q14(logic [15:0] a);
    longint unsigned idx;
    longint          v;
    idx = (longint'(a[13:0]) * 1024 + 8192) >> 14;
    if (idx > 1024) idx = 1024;
    v = a[14] ? sine_q14[1024 - idx] : sine_q14[idx];
    return a[15] ? -v : v;
  endfunction

  function automatic longint cos_q14(logic [15:0] a);
    return sin_q14(a + 16'h4000);
  endfunction

  function automatic longint mul_round(longint p);
    return (p + 8192) >>> 14;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint look_step(longint centre, logic [PIX_W-1:0] m,
                                       logic [TIME_W-1:0] dt);
    return (gain * longint'(dt) * (centre - longint'(m))) >>> STEP_SHIFT;
  endfunction

  function automatic void cfg_model(logic [CFG_IDX_W-1:0] idx,
                                    logic [CFG_DATA_W-1:0] d);
    case (idx)
      CFG_POS_X:       pos_x = longint'(signed'(d));
      CFG_POS_Y:       pos_y = longint'(signed'(d));
      CFG_POS_Z:       pos_z = longint'(signed'(d));
      CFG_CENTRE_X:    ctr_x = d[PIX_W-1:0];
      CFG_CENTRE_Y:    ctr_y = d[PIX_W-1:0];
      CFG_LOOK_GAIN:   gain = d[GAIN_W-1:0];
      CFG_PITCH_LIMIT: plimit = d[LIMIT_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic basis_t camera_basis(bit m, logic [PIX_W-1:0] mx,
                                          logic [PIX_W-1:0] my,
                                          logic [TIME_W-1:0] dt);
    basis_t r;
    longint dy, dp, cand, cp, cy, sy;
    if (!m) begin
      dy = look_step(ctr_x, mx, dt);
      dp = look_step(ctr_y, my, dt);
      cand = longint'(signed'(pitch)) + dp;
      yaw = yaw + dy[15:0];
      if (cand < plimit && cand > -plimit) pitch = cand[15:0];
      cp = cos_q14(pitch);
      cy = cos_q14(yaw);
      sy = sin_q14(yaw);
      r.vx = mul_round(cp * sy);
      r.vy = sin_q14(pitch);
      r.vz = mul_round(cp * cy);
    end else begin
      r.vx = 0;
      r.vy = 0;
      r.vz = ONE;
    end
    r.rx = sin_q14(yaw - 16'h4000);
    r.rz = cos_q14(yaw - 16'h4000);
    r.ux = clip(mul_round(-(r.rz * r.vy)), -ONE, ONE);
    r.uy = clip(mul_round(r.rz * r.vx - r.rx * r.vz), -ONE, ONE);
    r.uz = clip(mul_round(r.rx * r.vy), -ONE, ONE);
    r.tx = clip(pos_x + r.vx, -64'sd2147483648, 64'sd2147483647);
    r.ty = clip(pos_y + r.vy, -64'sd2147483648, 64'sd2147483647);
    r.tz = clip(pos_z + r.vz, -64'sd2147483648, 64'sd2147483647);
    return r;
  endfunction

  // register writes; the write enable is lowered by cfg_end
  task automatic cfg_wr(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= d;
    cfg_model(idx, d);
    @(posedge clk_i);
  endtask

  task automatic cfg_end();
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain(int unsigned extra);
    while (basis_q.size() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  // drive one pointer beat; returns at the accepting edge, valid left high
  task automatic send_beat(bit m, logic [PIX_W-1:0] mx, logic [PIX_W-1:0] my,
                           logic [TIME_W-1:0] dt, bit typed);
    bit rdy;
    if ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode <= m;
    in_ch.mouse_x <= mx;
    in_ch.mouse_y <= my;
    in_ch.frame_time <= dt;
    do begin
      @(negedge clk_i);
      rdy = in_ch.ready;
      @(posedge clk_i);
    end while (!rdy);
    begin
      basis_t b;
      b = camera_basis(m, mx, my, dt);
      basis_q.push_back(typed ? BASIS_FWD : b);
    end
  endtask

  task automatic send_random(int n);
    bit m;
    logic [TIME_W-1:0] dt;
    for (int i = 0; i < n; i++) begin
      m = $urandom_range(99) < 20;
      dt = $urandom_range(2) == 0 ? 16'($urandom_range(65535))
                                  : 16'($urandom_range(2000));
      send_beat(m, 12'($urandom_range(4095)), 12'($urandom_range(4095)), dt, 1'b0);
    end
  endtask

  task automatic phase_end();
    in_ch.valid <= 1'b0;
    drain(DRAIN_CYC);
  endtask

  task automatic cfg_random();
    cfg_wr(CFG_POS_X, $urandom);
    cfg_wr(CFG_POS_Y, $urandom);
    cfg_wr(CFG_POS_Z, $urandom);
    cfg_wr(CFG_CENTRE_X, $urandom_range(4095));
    cfg_wr(CFG_CENTRE_Y, $urandom_range(4095));
    cfg_wr(CFG_LOOK_GAIN, $urandom_range(1048575));
    cfg_wr(CFG_PITCH_LIMIT, $urandom_range(16384));
    cfg_end();
  endtask

  // receiver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = 600;
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= $urandom_range(99) >= recv_stall;
    end
  end

  function automatic void cmp_field(string nm, longint exp_v, longint act_v,
                                    ref bit bad);
    if (exp_v != act_v) begin
      bad = 1'b1;
      if (mismatches < 10)
        $display("mismatch %s: expected %0d, got %0d", nm, exp_v, act_v);
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (basis_q.size() == 0) begin
        failed = 1'b1;
        if (mismatches < 10) $display("unexpected output beat");
        mismatches++;
      end else begin
        basis_t e;
        bit bad;
        e = basis_q.pop_front();
        bad = 1'b0;
        cmp_field("view_x", e.vx, out_ch.view_x, bad);
        cmp_field("view_y", e.vy, out_ch.view_y, bad);
        cmp_field("view_z", e.vz, out_ch.view_z, bad);
        cmp_field("right_x", e.rx, out_ch.right_x, bad);
        cmp_field("right_z", e.rz, out_ch.right_z, bad);
        cmp_field("up_x", e.ux, out_ch.up_x, bad);
        cmp_field("up_y", e.uy, out_ch.up_y, bad);
        cmp_field("up_z", e.uz, out_ch.up_z, bad);
        cmp_field("target_x", e.tx, out_ch.target_x, bad);
        cmp_field("target_y", e.ty, out_ch.target_y, bad);
        cmp_field("target_z", e.tz, out_ch.target_z, bad);
        if (bad) begin
          failed = 1'b1;
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYC_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  look_row_t look_rows [] = '{
    '{1'b1, 12'd640,  12'd360,  16'd0,     1'b1},
    '{1'b0, 12'd640,  12'd360,  16'd0,     1'b1},
    '{1'b0, 12'd0,    12'd0,    16'd65535, 1'b0},
    '{1'b0, 12'd4095, 12'd4095, 16'd65535, 1'b0},
    '{1'b0, 12'd4095, 12'd0,    16'd65535, 1'b0},
    '{1'b0, 12'd0,    12'd4095, 16'd65535, 1'b0},
    '{1'b1, 12'd4095, 12'd4095, 16'd65535, 1'b0},
    '{1'b0, 12'd1000, 12'd360,  16'd1000,  1'b0},
    '{1'b0, 12'd640,  12'd0,    16'd65535, 1'b0},
    '{1'b0, 12'd640,  12'd0,    16'd65535, 1'b0},
    '{1'b0, 12'd640,  12'd4095, 16'd65535, 1'b0},
    '{1'b0, 12'd640,  12'd4095, 16'd65535, 1'b0},
    '{1'b0, 12'd640,  12'd4095, 16'd30000, 1'b0},
    '{1'b0, 12'd2000, 12'd2000, 16'd12345, 1'b0},
    '{1'b0, 12'd0,    12'd360,  16'd65535, 1'b0},
    '{1'b0, 12'd0,    12'd360,  16'd65535, 1'b0},
    '{1'b0, 12'd0,    12'd360,  16'd65535, 1'b0},
    '{1'b0, 12'd0,    12'd360,  16'd65535, 1'b0},
    '{1'b1, 12'd0,    12'd0,    16'd0,     1'b0}
  };

  initial begin
    in_ch.valid = 1'b0;
    in_ch.mode = 1'b0;
    in_ch.mouse_x = '0;
    in_ch.mouse_y = '0;
    in_ch.frame_time = '0;
    pos_x = 0; pos_y = 0; pos_z = 0;
    ctr_x = CENTRE_X_RST;
    ctr_y = CENTRE_Y_RST;
    gain = LOOK_GAIN_RST;
    plimit = PITCH_LIMIT_RST;
    yaw = '0;
    pitch = '0;
    build_sine();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values, no idling
    foreach (look_rows[i])
      send_beat(look_rows[i].mode, look_rows[i].mx, look_rows[i].my,
                look_rows[i].dt, look_rows[i].typed);
    phase_end();

    // upper extremes, sender idling
    cfg_wr(CFG_POS_X, 32'h7fff_ffff);
    cfg_wr(CFG_POS_Y, 32'h8000_0000);
    cfg_wr(CFG_POS_Z, 32'h7fff_ffff);
    cfg_wr(CFG_CENTRE_X, 32'd0);
    cfg_wr(CFG_CENTRE_Y, 32'd4095);
    cfg_wr(CFG_LOOK_GAIN, 32'd1048575);
    cfg_wr(CFG_PITCH_LIMIT, 32'd16384);
    cfg_end();
    send_idle = 51;
    send_random(70);
    phase_end();

    // frozen pitch, receiver stalling and one long hold-off
    cfg_wr(CFG_PITCH_LIMIT, 32'd0);
    cfg_wr(CFG_CENTRE_X, 32'd2048);
    cfg_wr(CFG_CENTRE_Y, 32'd2048);
    cfg_wr(CFG_POS_X, $urandom);
    cfg_end();
    send_idle = 0;
    recv_stall = 51;
    hold_req = 1'b1;
    send_random(70);
    phase_end();

    // random settings, light idling on both sides, one full drain midway
    cfg_random();
    send_idle = 7;
    recv_stall = 7;
    send_random(40);
    in_ch.valid <= 1'b0;
    drain(0);
    send_random(40);
    phase_end();

    // lower extremes, spare index ignored
    cfg_wr(CFG_POS_X, 32'h8000_0000);
    cfg_wr(CFG_POS_Y, 32'h7fff_ffff);
    cfg_wr(CFG_POS_Z, 32'h8000_0000);
    cfg_wr(CFG_CENTRE_X, 32'd4095);
    cfg_wr(CFG_CENTRE_Y, 32'd0);
    cfg_wr(CFG_LOOK_GAIN, 32'd0);
    cfg_wr(CFG_PITCH_LIMIT, 32'd1);
    cfg_wr(CFG_SPARE, 32'hffff_ffff);
    cfg_end();
    send_idle = 0;
    recv_stall = 0;
    send_random(40);
    phase_end();

    cfg_random();
    send_idle = 51;
    send_random(70);
    phase_end();

    cfg_random();
    send_idle = 0;
    recv_stall = 51;
    send_random(70);
    phase_end();

    if (!failed && basis_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
